[src/pabl_pkg.sv]
// Package with the widths and constants shared by the polygon area and lattice point block.
`default_nettype none

package pabl_pkg;

   // Widths of the accumulators and of the result fields.
   localparam int AreaWidth     = 61;
   localparam int TwiceWidth    = 60;
   localparam int BoundWidth    = 34;
   localparam int InteriorWidth = 59;
   localparam int DiffWidth     = TwiceWidth + 2;

   // A polygon needs at least this many vertices to enclose any area.
   localparam int MinVertices = 3;

   // Defaults for the top-level parameters.
   localparam int DefMaxVertices = 1024;
   localparam int DefCoordBits   = 24;

   // Sequencer state codes.
   localparam int StateWidth = 3;
   typedef logic [StateWidth-1:0] state_type;

   localparam state_type StIdle   = 3'd0;
   localparam state_type StMul1   = 3'd1;
   localparam state_type StMul2   = 3'd2;
   localparam state_type StAccum  = 3'd3;
   localparam state_type StGcd    = 3'd4;
   localparam state_type StFinish = 3'd5;
   localparam state_type StPick   = 3'd6;
   localparam state_type StOut    = 3'd7;

endpackage : pabl_pkg

`default_nettype wire

[src/polygon_area_boundary_lattice_top.sv]
// Top level of the polygon area and lattice point block: shoelace sum, edge gcds and Pick count.
`default_nettype none

// The block takes the vertices of a lattice polygon in order, one beat per vertex, with
// final_vertex set on the last one, and returns one result beat per polygon: twice the
// enclosed area as a magnitude, the number of lattice points on the boundary and the number
// of interior lattice points from Pick's theorem (clamped at zero). Every edge costs one
// signed cross product, made as two products on a single shared multiplier and folded into a
// 61-bit accumulator, plus the gcd of the absolute coordinate differences, found by a binary
// gcd that takes one halving or one subtraction step a cycle on COORD_BITS+1 bit values. The
// gcd loop therefore sets the rate: a vertex that opens an edge occupies the block through
// both products, the accumulation and every gcd step, while the first vertex of a polygon
// opens no edge unless it is also the final one. The final vertex runs its own edge and then
// the closing edge back to the first vertex, and the finish, Pick and output states then
// form the magnitude, the Pick numerator and the result beat in turn.
// req_ready is high only while the sequencer is idle. The result sits in an output register, so
// the next polygon may start while that beat still waits for rsp_ready; a second result waits
// in the final state until the first has been taken. Vertices beyond MAX_VERTICES are dropped
// and flagged through rsp_count_overflow, and a polygon with fewer than three vertices reports
// zero area and zero interior points.
module polygon_area_boundary_lattice_top
   import pabl_pkg::*;
#(
   parameter int MAX_VERTICES = DefMaxVertices,
   parameter int COORD_BITS   = DefCoordBits
) (
   input  wire                              clock,
   input  wire                              reset,
   // Vertex input channel.
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  signed [COORD_BITS-1:0]     req_vertex_x,
   input  wire  signed [COORD_BITS-1:0]     req_vertex_y,
   input  wire                              req_final_vertex,
   // Result channel.
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic        [TwiceWidth-1:0]     rsp_twice_area,
   output logic        [BoundWidth-1:0]     rsp_boundary_count,
   output logic        [InteriorWidth-1:0]  rsp_interior_count,
   output logic                             rsp_too_few_vertices,
   output logic                             rsp_count_overflow
);

   // Derived widths: the vertex counter must hold MAX_VERTICES itself, the gcd works on the
   // magnitude of a coordinate difference, and the shift count covers every factor of two.
   localparam int CountWidth = $clog2(MAX_VERTICES + 1);
   localparam int GcdWidth   = COORD_BITS + 1;
   localparam int ShiftWidth = $clog2(GcdWidth + 1);
   localparam int ProdWidth  = 2 * COORD_BITS;

   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_VERTICES);
   localparam logic [CountWidth-1:0] CountMin = CountWidth'(MinVertices);

   // Sequencer state.
   state_type state_ff, state_in;

   // Polygon state kept between vertices.
   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in;
   logic signed [COORD_BITS-1:0] first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff,  prev_x_in;
   logic signed [COORD_BITS-1:0] prev_y_ff,  prev_y_in;
   logic [AreaWidth-1:0]         area_ff,    area_in;
   logic [BoundWidth-1:0]        bound_ff,   bound_in;
   logic [CountWidth-1:0]        count_ff,   count_in;
   logic                         overflow_ff, overflow_in;

   // The edge being worked on runs from point a to point b.
   logic signed [COORD_BITS-1:0] ax_ff, ax_in;
   logic signed [COORD_BITS-1:0] ay_ff, ay_in;
   logic signed [COORD_BITS-1:0] bx_ff, bx_in;
   logic signed [COORD_BITS-1:0] by_ff, by_in;
   logic                         last_ff, last_in;
   logic                         closing_ff, closing_in;

   // Shared multiplier and its product register.
   logic signed [COORD_BITS-1:0] mul_a;
   logic signed [COORD_BITS-1:0] mul_b;
   logic signed [ProdWidth-1:0]  mul_p;
   logic signed [ProdWidth-1:0]  prod_ff, prod_in;
   logic [AreaWidth-1:0]         prod_ext;

   // Binary gcd working registers.
   logic [GcdWidth-1:0]   ga_ff, ga_in;
   logic [GcdWidth-1:0]   gb_ff, gb_in;
   logic [ShiftWidth-1:0] gk_ff, gk_in;
   logic [GcdWidth-1:0]   dx;
   logic [GcdWidth-1:0]   dy;
   logic [GcdWidth-1:0]   abs_dx;
   logic [GcdWidth-1:0]   abs_dy;
   logic                  gcd_done;
   logic [BoundWidth-1:0] gcd_value;

   // Final arithmetic.
   logic [TwiceWidth-1:0] mag_ff, mag_in;
   logic [DiffWidth-1:0]  diff_ff, diff_in;
   logic [AreaWidth-1:0]  area_neg;
   logic                  few;
   logic                  out_free;

   // Result register.
   logic                     rsp_valid_ff,  rsp_valid_in;
   logic [TwiceWidth-1:0]    rsp_area_ff,   rsp_area_in;
   logic [BoundWidth-1:0]    rsp_bound_ff,  rsp_bound_in;
   logic [InteriorWidth-1:0] rsp_inter_ff,  rsp_inter_in;
   logic                     rsp_few_ff,    rsp_few_in;
   logic                     rsp_ovf_ff,    rsp_ovf_in;

   // The multiplier forms a.x * b.y in StMul1 and b.x * a.y in StMul2.
   always_comb begin
      if (state_ff == StMul1) begin
         mul_a = ax_ff;
         mul_b = by_ff;
      end else begin
         mul_a = bx_ff;
         mul_b = ay_ff;
      end
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = {{(AreaWidth - ProdWidth){prod_ff[ProdWidth-1]}}, prod_ff};

   // Absolute coordinate differences of the current edge, one bit wider than a coordinate.
   assign dx     = {ax_ff[COORD_BITS-1], ax_ff} - {bx_ff[COORD_BITS-1], bx_ff};
   assign dy     = {ay_ff[COORD_BITS-1], ay_ff} - {by_ff[COORD_BITS-1], by_ff};
   assign abs_dx = dx[GcdWidth-1] ? (GcdWidth'(0) - dx) : dx;
   assign abs_dy = dy[GcdWidth-1] ? (GcdWidth'(0) - dy) : dy;

   // Once either operand reaches zero the other, scaled back by the common powers of two,
   // is the gcd. Two zero operands give zero, which is right for a degenerate edge.
   assign gcd_done  = (ga_ff == '0) || (gb_ff == '0);
   assign gcd_value = BoundWidth'(ga_ff | gb_ff) << gk_ff;

   assign area_neg = AreaWidth'(0) - area_ff;
   assign few      = (count_ff < CountMin);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == StIdle);

   always_comb begin
      state_in    = state_ff;
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      area_in     = area_ff;
      bound_in    = bound_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      bx_in       = bx_ff;
      by_in       = by_ff;
      last_in     = last_ff;
      closing_in  = closing_ff;
      prod_in     = prod_ff;
      ga_in       = ga_ff;
      gb_in       = gb_ff;
      gk_in       = gk_ff;
      mag_in      = mag_ff;
      diff_in     = diff_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      rsp_bound_in = rsp_bound_ff;
      rsp_inter_in = rsp_inter_ff;
      rsp_few_in   = rsp_few_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               last_in    = req_final_vertex;
               closing_in = 1'b0;
               if (count_ff >= CountMax) begin
                  // Vertex dropped; only the closing edge remains if it is the last one.
                  overflow_in = 1'b1;
                  if (req_final_vertex) begin
                     ax_in      = prev_x_ff;
                     ay_in      = prev_y_ff;
                     bx_in      = first_x_ff;
                     by_in      = first_y_ff;
                     closing_in = 1'b1;
                     state_in   = StMul1;
                  end
               end else if (count_ff == '0) begin
                  // First vertex: no edge yet. A lone vertex closes onto itself.
                  first_x_in = req_vertex_x;
                  first_y_in = req_vertex_y;
                  prev_x_in  = req_vertex_x;
                  prev_y_in  = req_vertex_y;
                  count_in   = count_ff + CountWidth'(1);
                  if (req_final_vertex) begin
                     ax_in      = req_vertex_x;
                     ay_in      = req_vertex_y;
                     bx_in      = req_vertex_x;
                     by_in      = req_vertex_y;
                     closing_in = 1'b1;
                     state_in   = StMul1;
                  end
               end else begin
                  ax_in     = prev_x_ff;
                  ay_in     = prev_y_ff;
                  bx_in     = req_vertex_x;
                  by_in     = req_vertex_y;
                  prev_x_in = req_vertex_x;
                  prev_y_in = req_vertex_y;
                  count_in  = count_ff + CountWidth'(1);
                  state_in  = StMul1;
               end
            end
         end

         StMul1: begin
            prod_in  = mul_p;
            ga_in    = abs_dx;
            gb_in    = abs_dy;
            gk_in    = '0;
            state_in = StMul2;
         end

         StMul2: begin
            area_in  = area_ff + prod_ext;
            prod_in  = mul_p;
            state_in = StAccum;
         end

         StAccum: begin
            area_in  = area_ff - prod_ext;
            state_in = StGcd;
         end

         StGcd: begin
            if (gcd_done) begin
               bound_in = bound_ff + gcd_value;
               if (closing_ff) begin
                  state_in = StFinish;
               end else if (last_ff) begin
                  ax_in      = prev_x_ff;
                  ay_in      = prev_y_ff;
                  bx_in      = first_x_ff;
                  by_in      = first_y_ff;
                  closing_in = 1'b1;
                  state_in   = StMul1;
               end else begin
                  state_in = StIdle;
               end
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + ShiftWidth'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end

         StFinish: begin
            // A sum that reads as the most negative value has a magnitude of zero.
            if (few) begin
               mag_in = '0;
            end else if (area_ff[AreaWidth-1]) begin
               mag_in = area_neg[TwiceWidth-1:0];
            end else begin
               mag_in = area_ff[TwiceWidth-1:0];
            end
            state_in = StPick;
         end

         StPick: begin
            diff_in  = DiffWidth'(mag_ff) + DiffWidth'(2) - DiffWidth'(bound_ff);
            state_in = StOut;
         end

         StOut: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = mag_ff;
               rsp_bound_in = bound_ff;
               rsp_few_in   = few;
               rsp_ovf_in   = overflow_ff;
               // The Pick numerator is halved, rounding down, only when it is positive.
               if (!few && !diff_ff[DiffWidth-1] && (diff_ff != '0)) begin
                  rsp_inter_in = diff_ff[InteriorWidth:1];
               end else begin
                  rsp_inter_in = '0;
               end
               first_x_in  = '0;
               first_y_in  = '0;
               prev_x_in   = '0;
               prev_y_in   = '0;
               area_in     = '0;
               bound_in    = '0;
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = StIdle;
            end
         end

         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         area_ff      <= '0;
         bound_ff     <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         last_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         area_ff      <= area_in;
         bound_ff     <= bound_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         last_ff      <= last_in;
         closing_ff   <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      prod_ff      <= prod_in;
      ga_ff        <= ga_in;
      gb_ff        <= gb_in;
      gk_ff        <= gk_in;
      mag_ff       <= mag_in;
      diff_ff      <= diff_in;
      rsp_area_ff  <= rsp_area_in;
      rsp_bound_ff <= rsp_bound_in;
      rsp_inter_ff <= rsp_inter_in;
      rsp_few_ff   <= rsp_few_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_twice_area       = rsp_area_ff;
   assign rsp_boundary_count   = rsp_bound_ff;
   assign rsp_interior_count   = rsp_inter_ff;
   assign rsp_too_few_vertices = rsp_few_ff;
   assign rsp_count_overflow   = rsp_ovf_ff;

endmodule : polygon_area_boundary_lattice_top

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the polygon area and lattice point block.
`timescale 1ns / 1ps

// The testbench feeds polygon outlines into the block one vertex beat at a time. It keeps
// its own running model of the shoelace sum, the edge gcd sum and the vertex count. When a
// beat carrying final_vertex is accepted, the model closes the outline and queues the
// result that the block must return. Every result beat is checked field by field against
// the oldest queued polygon.
//
// Both channels idle at random. Each side draws a random wait before each beat while
// pacing is enabled, and the random phase switches pacing off for stretches so that
// back-to-back traffic is covered as well.
module tb_top
   import pabl_pkg::*;
();

   localparam int CoordBits   = DefCoordBits;
   localparam int MaxVertices = DefMaxVertices;

   // The run is about 1700 beats, each costing at most a sender gap, the work of the block
   // and a receiver stall. The limit is several times that.
   localparam int CycleLimit  = 4000000;

   // The drain time follows the return of the last expected result.
   localparam int DrainCycles = 200;
   localparam int RandomBeats = 640;

   typedef logic signed [CoordBits-1:0] coord_type;

   localparam coord_type CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
   localparam coord_type CoordMax = {1'b0, {(CoordBits-1){1'b1}}};

   typedef struct packed {
      logic [TwiceWidth-1:0]    twice_area;
      logic [BoundWidth-1:0]    boundary_count;
      logic [InteriorWidth-1:0] interior_count;
      logic                     too_few_vertices;
      logic                     count_overflow;
   } polygon_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   coord_type                req_vertex_x = '0;
   coord_type                req_vertex_y = '0;
   logic                     req_final_vertex = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [TwiceWidth-1:0]    rsp_twice_area;
   logic [BoundWidth-1:0]    rsp_boundary_count;
   logic [InteriorWidth-1:0] rsp_interior_count;
   logic                     rsp_too_few_vertices;
   logic                     rsp_count_overflow;

   // This is the model state for the outline that is currently open. It mirrors the block's
   // registers and returns to zero once a polygon has been closed.
   coord_type                first_x = '0;
   coord_type                first_y = '0;
   coord_type                prev_x = '0;
   coord_type                prev_y = '0;
   logic [AreaWidth-1:0]     area_acc = '0;
   logic [BoundWidth-1:0]    boundary_acc = '0;
   int                       vertices_taken = 0;
   logic                     overflow_flag = 1'b0;

   // These hold the polygons whose result beats are still due, oldest first.
   polygon_result_type       expected_polygons[$];

   // This is the outline under construction, sent by send_outline.
   coord_type                outline_x[$];
   coord_type                outline_y[$];

   bit                       pacing_on = 1'b1;
   int                       cycle_count = 0;
   int                       mismatch_count = 0;
   int                       vertices_sent = 0;
   int                       polygons_sent = 0;
   int                       results_checked = 0;
   int                       few_results = 0;
   int                       overflow_results = 0;

   polygon_area_boundary_lattice_top #(
      .MAX_VERTICES (MaxVertices),
      .COORD_BITS   (CoordBits)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vertex_x         (req_vertex_x),
      .req_vertex_y         (req_vertex_y),
      .req_final_vertex     (req_final_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_twice_area       (rsp_twice_area),
      .rsp_boundary_count   (rsp_boundary_count),
      .rsp_interior_count   (rsp_interior_count),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_count_overflow   (rsp_count_overflow)
   );

   always #5 clock = ~clock;

   // This is the watchdog. A hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Euclid's algorithm. The block uses a binary gcd, but the value is the same. By
   // convention gcd(0, 0) is 0, so a repeated vertex adds nothing to the boundary.
   function automatic longint unsigned lattice_gcd(input longint unsigned a,
                                                   input longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // This adds one edge from (ax, ay) to (bx, by). The cross product wraps into the 61-bit
   // area sum and the gcd of the absolute differences wraps into the boundary sum.
   task automatic accumulate_edge(input longint ax, input longint ay,
                                  input longint bx, input longint by);
      longint          cross_prod;
      longint unsigned dx;
      longint unsigned dy;
      cross_prod = ax * by - bx * ay;
      area_acc = area_acc + cross_prod[AreaWidth-1:0];
      dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
      dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
      boundary_acc = boundary_acc + BoundWidth'(lattice_gcd(dx, dy));
   endtask

   // This updates the model with one accepted vertex. On the final vertex it closes the
   // outline and queues the expected result beat.
   task automatic predict_vertex(input coord_type x, input coord_type y, input logic is_final);
      logic [AreaWidth-1:0] negated;
      logic [TwiceWidth-1:0] magnitude;
      logic [63:0] numer_area;
      logic [63:0] numer_bound;
      logic few;
      polygon_result_type res;
      if (vertices_taken >= MaxVertices) begin
         // A vertex beyond the bound is dropped, but it is remembered.
         overflow_flag = 1'b1;
      end else begin
         if (vertices_taken == 0) begin
            first_x = x;
            first_y = y;
         end else begin
            accumulate_edge(prev_x, prev_y, x, y);
         end
         prev_x = x;
         prev_y = y;
         vertices_taken++;
      end
      if (is_final) begin
         accumulate_edge(prev_x, prev_y, first_x, first_y);
         negated = -area_acc;
         magnitude = area_acc[AreaWidth-1] ? negated[TwiceWidth-1:0]
                                           : area_acc[TwiceWidth-1:0];
         few = (vertices_taken < MinVertices);
         if (few) begin
            magnitude = '0;
         end
         // Pick's numerator is rounded down when it is odd and clamped when it is negative.
         numer_area = 64'(magnitude) + 64'd2;
         numer_bound = 64'(boundary_acc);
         res.twice_area = magnitude;
         res.boundary_count = boundary_acc;
         res.interior_count = (!few && numer_area > numer_bound)
                              ? InteriorWidth'((numer_area - numer_bound) >> 1) : '0;
         res.too_few_vertices = few;
         res.count_overflow = overflow_flag;
         expected_polygons.push_back(res);
         first_x = '0;
         first_y = '0;
         prev_x = '0;
         prev_y = '0;
         area_acc = '0;
         boundary_acc = '0;
         vertices_taken = 0;
         overflow_flag = 1'b0;
      end
   endtask

   // This offers one vertex beat and waits until it is accepted. Valid is held high after
   // acceptance. It falls only if the next beat draws a gap, so that valid never gets two
   // assignments in one step.
   task automatic send_vertex(input coord_type x, input coord_type y, input logic is_final);
      int gap;
      gap = pacing_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_final_vertex <= is_final;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_vertex(x, y, is_final);
      vertices_sent++;
   endtask

   task automatic add_point(input coord_type x, input coord_type y);
      outline_x.push_back(x);
      outline_y.push_back(y);
   endtask

   // This sends the queued outline with final_vertex on its last vertex, then clears it.
   task automatic send_outline();
      for (int i = 0; i < outline_x.size(); i++) begin
         send_vertex(outline_x[i], outline_y[i], i == outline_x.size() - 1);
      end
      outline_x.delete();
      outline_y.delete();
      polygons_sent++;
   endtask

   // This draws one coordinate in the given style: full range, small, moderate, on a
   // power-of-two grid, or one of the edge values of the range.
   function automatic coord_type random_coord(input int mode, input int grid_shift);
      coord_type value;
      case (mode)
         0: begin
            value = coord_type'($urandom());
         end
         1: begin
            value = coord_type'(int'($urandom_range(0, 32)) - 16);
         end
         2: begin
            value = coord_type'(int'($urandom_range(0, 2000)) - 1000);
         end
         3: begin
            value = coord_type'((int'($urandom_range(0, 16)) - 8) <<< grid_shift);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: value = CoordMin;
               1: value = CoordMax;
               2: value = '0;
               3: value = '1;
               default: value = coord_type'(1);
            endcase
         end
      endcase
      return value;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // This is the result side. It stalls at random before each beat, then takes the beat
   // and compares it with the oldest queued polygon.
   initial begin : result_checker
      int stall;
      polygon_result_type want;
      wait (reset == 1'b0);
      forever begin
         stall = pacing_on ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_polygons.size() == 0) begin
            $display("%0t: result beat with no polygon outstanding, actual area %0d",
                     $time, rsp_twice_area);
            mismatch_count++;
         end else begin
            want = expected_polygons.pop_front();
            check_field("twice_area", 64'(want.twice_area), 64'(rsp_twice_area));
            check_field("boundary_count", 64'(want.boundary_count), 64'(rsp_boundary_count));
            check_field("interior_count", 64'(want.interior_count), 64'(rsp_interior_count));
            check_field("too_few_vertices", 64'(want.too_few_vertices),
                        64'(rsp_too_few_vertices));
            check_field("count_overflow", 64'(want.count_overflow), 64'(rsp_count_overflow));
            if (want.too_few_vertices) few_results++;
            if (want.count_overflow) overflow_results++;
         end
         results_checked++;
      end
   end

   // These outlines reach the ends of the coordinate range, with bit patterns that set and
   // clear every coordinate bit.
   task automatic test_coordinate_extremes();
      add_point(CoordMin, CoordMin);
      add_point(CoordMax, CoordMin);
      add_point(CoordMax, CoordMax);
      add_point(CoordMin, CoordMax);
      send_outline();
      add_point(CoordMax, CoordMin);
      add_point(CoordMin, '0);
      add_point('1, CoordMax);
      send_outline();
      add_point(coord_type'(24'h555555), coord_type'(24'haaaaaa));
      add_point(coord_type'(24'haaaaaa), coord_type'(24'h555555));
      add_point(coord_type'(24'h0f0f0f), coord_type'(24'hf0f0f0));
      send_outline();
   endtask

   // These are the degenerate outlines. One or two vertices report no area, and a collinear
   // triangle has zero area and a Pick numerator that must be clamped.
   task automatic test_degenerate_outlines();
      add_point(coord_type'(7), coord_type'(-3));
      send_outline();
      add_point(coord_type'(-6), coord_type'(2));
      add_point(coord_type'(6), coord_type'(-2));
      send_outline();
      add_point(coord_type'(0), coord_type'(0));
      add_point(coord_type'(2), coord_type'(0));
      add_point(coord_type'(4), coord_type'(0));
      send_outline();
   endtask

   // These are lattice shapes with known counts. The rectangle is sent in both winding
   // directions, so the negative shoelace sum must come back as a magnitude. The
   // self-crossing outline gives a Pick numerator that need not be even.
   task automatic test_lattice_shapes();
      add_point(coord_type'(0), coord_type'(0));
      add_point(coord_type'(4), coord_type'(0));
      add_point(coord_type'(4), coord_type'(3));
      add_point(coord_type'(0), coord_type'(3));
      send_outline();
      add_point(coord_type'(0), coord_type'(0));
      add_point(coord_type'(0), coord_type'(3));
      add_point(coord_type'(4), coord_type'(3));
      add_point(coord_type'(4), coord_type'(0));
      send_outline();
      add_point(coord_type'(0), coord_type'(0));
      add_point(coord_type'(7), coord_type'(1));
      add_point(coord_type'(1), coord_type'(5));
      add_point(coord_type'(6), coord_type'(6));
      send_outline();
   endtask

   // The outline fills the vertex bound, runs past it and closes on a dropped vertex, so
   // it must still close from the last kept vertex.
   task automatic test_vertex_bound();
      for (int i = 0; i < MaxVertices + 2; i++) begin
         add_point(random_coord(2, 0), random_coord(1, 0));
      end
      send_outline();
   endtask

   // These are random outlines. Most have three to ten vertices in a single coordinate
   // style. A few are too short, a few are long, some are axis-aligned rectangles and some
   // repeat a vertex. Pacing is switched on and off now and then.
   task automatic test_random_polygons();
      int start_beats;
      int count;
      int mode;
      int grid_shift;
      int pick;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      start_beats = vertices_sent;
      while (vertices_sent - start_beats < RandomBeats) begin
         if ($urandom_range(0, 15) == 0) pacing_on = !pacing_on;
         mode = $urandom_range(0, 4);
         grid_shift = $urandom_range(0, 19);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            count = $urandom_range(1, 2);
         end else if (pick < 92) begin
            count = $urandom_range(3, 10);
         end else begin
            count = $urandom_range(11, 40);
         end
         if ($urandom_range(0, 9) == 0) begin
            x0 = random_coord(mode, grid_shift);
            y0 = random_coord(mode, grid_shift);
            x1 = random_coord(mode, grid_shift);
            y1 = random_coord(mode, grid_shift);
            add_point(x0, y0);
            add_point(x1, y0);
            add_point(x1, y1);
            add_point(x0, y1);
         end else begin
            for (int i = 0; i < count; i++) begin
               if (i > 0 && $urandom_range(0, 11) == 0) begin
                  add_point(outline_x[i-1], outline_y[i-1]);
               end else begin
                  add_point(random_coord(mode, grid_shift), random_coord(mode, grid_shift));
               end
            end
         end
         send_outline();
      end
      pacing_on = 1'b1;
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_coordinate_extremes();
      test_degenerate_outlines();
      test_lattice_shapes();
      test_vertex_bound();
      test_random_polygons();
      req_valid <= 1'b0;
      while (expected_polygons.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d vertex beats in %0d polygons, checked %0d result beats.",
               vertices_sent, polygons_sent, results_checked);
      $display("Short outlines: %0d, outlines past the vertex bound: %0d, mismatches: %0d.",
               few_results, overflow_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule : tb_top
